/* src/tscc_pkg.sv */
// ----------------------------------------------------------------------------
// tscc_pkg
// Shared types and constants for the transport stream continuity counter
// restamper: transaction payloads, per-PID table entry and memory request.
// ----------------------------------------------------------------------------
package tscc_pkg;

	localparam int PID_SLOTS = 8192;
	localparam int PID_W     = 13;
	localparam int CC_W      = 4;
	localparam int SLOT_AW   = (PID_SLOTS > 1) ? $clog2(PID_SLOTS) : 1;

	localparam logic [PID_W-1:0] NULL_PID = 13'h1FFF;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [PID_W-1:0] pid;
	} tscc_in_t;

	typedef struct packed {
		logic [PID_W-1:0] pid_out;
		logic [CC_W-1:0]  continuity;
		logic             restamped;
	} tscc_out_t;

	// one table slot: seen flag and last counter value
	typedef struct packed {
		logic            seen;
		logic [CC_W-1:0] cc;
	} tscc_entry_t;

	localparam int ENTRY_W = $bits(tscc_entry_t);

	typedef struct packed {
		logic               rd_en;
		logic [SLOT_AW-1:0] rd_addr;
		logic               wr_en;
		logic [SLOT_AW-1:0] wr_addr;
		tscc_entry_t        wr_data;
	} tscc_mem_req_t;

endpackage

/* src/ts_continuity_counter_restamp.sv */
// a packet's table entry is read into the RAM read register on accept, and its
// result moves to the output register from UPDATE, which waits while the output stalls
// a new transaction is taken only once the previous one has left UPDATE or CLEAR
// a clear transaction sweeps all 8192 table entries, one entry a cycle
// reset: the same sweep runs first; no input is taken until it ends
// ----------------------------------------------------------------------------
// ts_continuity_counter_restamp
// Keeps a 4-bit continuity counter per PID and restamps packets with the
// next counter value; the per-PID table lives in a synchronous RAM.
// ----------------------------------------------------------------------------
module ts_continuity_counter_restamp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tscc_pkg::tscc_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tscc_pkg::tscc_out_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import tscc_pkg::*;

	logic                 restamp_enable_q;
	tscc_mem_req_t        mem_req;
	logic [ENTRY_W-1:0]   mem_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restamp_enable_q <= 1'b0;
		end else if (cfg_we) begin
			restamp_enable_q <= cfg_wdata;
		end
	end

	tscc_ram #(
		.DEPTH (PID_SLOTS),
		.WIDTH (ENTRY_W),
		.AW    (SLOT_AW)
	) u_table (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (mem_rd_data)
	);

	tscc_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.restamp_enable (restamp_enable_q),
		.mem_req        (mem_req),
		.mem_rd_data    (mem_rd_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data)
	);

`ifndef SYNTHESIS
	// one transaction at a time: no accept right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous transaction in progress");

	a_no_null_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.restamped |-> out_data.pid_out != NULL_PID)
		else $error("null pid restamped");

	a_zero_cc_unstamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.restamped |-> out_data.continuity == '0)
		else $error("nonzero continuity on pass-through packet");

	// table writes never collide with a lookup of the same transaction
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> !mem_req.rd_en)
		else $error("table read and write in the same cycle");
`endif

endmodule

/* src/tscc_ram.sv */
// ----------------------------------------------------------------------------
// tscc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tscc_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* src/tscc_engine.sv */
// ----------------------------------------------------------------------------
// tscc_engine
// Read-modify-write sequencer over the per-PID table: lookup on accept,
// counter update and result in UPDATE once the output register is free,
// and a clearing sweep after reset and for every clear transaction.
// ----------------------------------------------------------------------------
module tscc_engine (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  tscc_pkg::tscc_in_t      in_data,
	input  logic                    restamp_enable,
	output tscc_pkg::tscc_mem_req_t mem_req,
	input  logic [tscc_pkg::ENTRY_W-1:0] mem_rd_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output tscc_pkg::tscc_out_t     out_data
);
	import tscc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_UPDATE = 3'b010,
		ST_CLEAR  = 3'b100
	} state_t;

	state_t             state_q;
	logic [SLOT_AW-1:0] sweep_q;
	logic [PID_W-1:0]   pid_s1;
	logic               out_valid_q;
	tscc_out_t          out_data_q;

	tscc_entry_t        rd_entry;
	logic               accept;
	logic               advance;
	logic               in_range;
	logic               stamp;
	logic [CC_W-1:0]    cc_new;
	logic               sweep_last;

	assign rd_entry   = tscc_entry_t'(mem_rd_data);
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign advance    = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);
	assign sweep_last = (sweep_q == SLOT_AW'(PID_SLOTS - 1));

	// pids at or above the table size have no slot and pass like the null pid
	assign in_range = ({1'b0, pid_s1} < (PID_W + 1)'(PID_SLOTS));
	assign stamp    = restamp_enable && (pid_s1 != NULL_PID) && in_range;
	assign cc_new   = rd_entry.seen ? rd_entry.cc + CC_W'(1) : '0;

	always_comb begin
		mem_req         = '0;
		mem_req.rd_en   = accept && (in_data.operation == OP_PACKET);
		mem_req.rd_addr = in_data.pid[SLOT_AW-1:0];
		if (state_q == ST_CLEAR) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = sweep_q;
			mem_req.wr_data = '0;
		end else begin
			mem_req.wr_en           = advance && stamp;
			mem_req.wr_addr         = pid_s1[SLOT_AW-1:0];
			mem_req.wr_data.seen    = 1'b1;
			mem_req.wr_data.cc      = cc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.operation == OP_CLEAR) begin
							state_q <= ST_CLEAR;
							sweep_q <= '0;
						end else begin
							state_q <= ST_UPDATE;
						end
					end
				end
				ST_UPDATE: begin
					if (advance) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + SLOT_AW'(1);
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					sweep_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pid_s1 <= in_data.pid;
		end
	end

	// output register parts the update from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.pid_out    <= pid_s1;
			out_data_q.continuity <= stamp ? cc_new : '0;
			out_data_q.restamped  <= stamp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
